@@ hw/rtl/skvt_pkg.sv @@
package skvt_pkg;

  localparam int DEFAULT_DEPTH = 64;
  localparam int KEY_W = 16;
  localparam int VAL_W = 32;
  localparam int CMD_W = 2;
  localparam int STATUS_W = 2;
  localparam int COUNT_OUT_W = 7;

  localparam logic [CMD_W-1:0] CMD_ADD = 2'd0;
  localparam logic [CMD_W-1:0] CMD_UPDATE = 2'd1;
  localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd2;

  localparam logic [STATUS_W-1:0] ST_OK = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FAIL = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL = 2'd2;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SEARCH,
    S_PROBE,
    S_DISPATCH,
    S_SHIFT_UP,
    S_SHIFT_DOWN,
    S_RESP
  } skvt_state_t;

endpackage

@@ hw/rtl/skvt_ram.sv @@
module skvt_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ hw/rtl/sorted_key_value_table_top.sv @@
// Sequence: take the word, binary-search the sorted keys (each probe reads the
//   RAM, then compares), dispatch the command, shift entries up for an add or
//   down for a delete, then load the result.
// Throughput: one command at a time; shifting moves one entry per cycle,
//   limited by the single read and single write port of the entry RAM.
// Reset: the entry count clears, so the table is empty; RAM stays undefined.
module sorted_key_value_table_top #(
  parameter int TABLE_DEPTH = skvt_pkg::DEFAULT_DEPTH
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [skvt_pkg::CMD_W-1:0]          command,
  input  logic [skvt_pkg::KEY_W-1:0]          year_key,
  input  logic signed [skvt_pkg::VAL_W-1:0]   entry_value,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [skvt_pkg::STATUS_W-1:0]       status,
  output logic [skvt_pkg::COUNT_OUT_W-1:0]    entry_count
);

  import skvt_pkg::*;

  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam int EW = KEY_W + VAL_W;

  skvt_state_t state, state_next;

  logic [CMD_W-1:0]    cmd_r, cmd_r_next;
  logic [KEY_W-1:0]    key_r, key_r_next;
  logic [VAL_W-1:0]    val_r, val_r_next;
  logic [CW-1:0]       count, count_next;
  logic [CW-1:0]       lo, lo_next;
  logic [CW-1:0]       hi, hi_next;
  logic                hit, hit_next;
  logic [CW-1:0]       cur, cur_next;
  logic [AW-1:0]       wa, wa_next;
  logic                wr_pend, wr_pend_next;
  logic [STATUS_W-1:0] res_status, res_status_next;
  logic                out_valid_next;
  logic [STATUS_W-1:0] status_next;
  logic [COUNT_OUT_W-1:0] entry_count_next;

  logic [CW:0]         mid_sum;
  logic [CW-1:0]       mid;
  logic [CW-1:0]       cur_dec;
  logic [CW-1:0]       cur_inc;
  logic [CW+COUNT_OUT_W-1:0] count_ext;

  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [EW-1:0] ram_wdata;
  logic [AW-1:0] ram_raddr;
  logic [EW-1:0] ram_rdata;
  logic [KEY_W-1:0] rd_key;

  skvt_ram #(
    .WIDTH(EW),
    .DEPTH(TABLE_DEPTH)
  ) u_entry_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  assign rd_key    = ram_rdata[EW-1:VAL_W];
  assign mid_sum   = {1'b0, lo} + {1'b0, hi};
  assign mid       = mid_sum[CW:1];
  assign cur_dec   = cur - CW'(1);
  assign cur_inc   = cur + CW'(1);
  assign count_ext = (CW + COUNT_OUT_W)'(count);
  assign in_stall  = (state != S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      out_valid <= 1'b0;
      wr_pend   <= 1'b0;
    end else begin
      state     <= state_next;
      count     <= count_next;
      out_valid <= out_valid_next;
      wr_pend   <= wr_pend_next;
    end
    cmd_r       <= cmd_r_next;
    key_r       <= key_r_next;
    val_r       <= val_r_next;
    lo          <= lo_next;
    hi          <= hi_next;
    hit         <= hit_next;
    cur         <= cur_next;
    wa          <= wa_next;
    res_status  <= res_status_next;
    status      <= status_next;
    entry_count <= entry_count_next;
  end

  always_comb begin
    state_next       = state;
    cmd_r_next       = cmd_r;
    key_r_next       = key_r;
    val_r_next       = val_r;
    count_next       = count;
    lo_next          = lo;
    hi_next          = hi;
    hit_next         = hit;
    cur_next         = cur;
    wa_next          = wa;
    wr_pend_next     = wr_pend;
    res_status_next  = res_status;
    out_valid_next   = out_valid && out_stall;
    status_next      = status;
    entry_count_next = entry_count;
    ram_we           = 1'b0;
    ram_waddr        = wa;
    ram_wdata        = ram_rdata;
    ram_raddr        = mid[AW-1:0];

    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd_r_next = command;
          key_r_next = year_key;
          val_r_next = entry_value;
          lo_next    = '0;
          hi_next    = count;
          hit_next   = 1'b0;
          state_next = S_SEARCH;
        end
      end
      S_SEARCH: begin
        if (lo < hi) begin
          state_next = S_PROBE;
        end else begin
          state_next = S_DISPATCH;
        end
      end
      S_PROBE: begin
        if (rd_key < key_r) begin
          lo_next = mid + CW'(1);
        end else begin
          hi_next = mid;
        end
        if (rd_key == key_r) begin
          hit_next = 1'b1;
        end
        state_next = S_SEARCH;
      end
      S_DISPATCH: begin
        state_next      = S_RESP;
        res_status_next = ST_FAIL;
        case (cmd_r)
          CMD_ADD: begin
            if (hit) begin
              res_status_next = ST_FAIL;
            end else if (count >= CW'(TABLE_DEPTH)) begin
              res_status_next = ST_FULL;
            end else begin
              cur_next     = count;
              wr_pend_next = 1'b0;
              state_next   = S_SHIFT_UP;
            end
          end
          CMD_UPDATE: begin
            if (!hit) begin
              res_status_next = ST_FAIL;
            end else if (val_r[VAL_W-1]) begin
              cur_next     = lo + CW'(1);
              wr_pend_next = 1'b0;
              state_next   = S_SHIFT_DOWN;
            end else begin
              ram_we          = 1'b1;
              ram_waddr       = lo[AW-1:0];
              ram_wdata       = {key_r, val_r};
              res_status_next = ST_OK;
            end
          end
          CMD_CLEAR: begin
            count_next      = '0;
            res_status_next = ST_OK;
          end
          default: begin
            res_status_next = ST_FAIL;
          end
        endcase
      end
      S_SHIFT_UP: begin
        ram_we = wr_pend;
        if (cur > lo) begin
          ram_raddr    = cur_dec[AW-1:0];
          wa_next      = cur[AW-1:0];
          wr_pend_next = 1'b1;
          cur_next     = cur_dec;
        end else if (!wr_pend) begin
          ram_we          = 1'b1;
          ram_waddr       = lo[AW-1:0];
          ram_wdata       = {key_r, val_r};
          count_next      = count + CW'(1);
          res_status_next = ST_OK;
          state_next      = S_RESP;
        end else begin
          wr_pend_next = 1'b0;
        end
      end
      S_SHIFT_DOWN: begin
        ram_we = wr_pend;
        if (cur < count) begin
          ram_raddr    = cur[AW-1:0];
          wa_next      = cur_dec[AW-1:0];
          wr_pend_next = 1'b1;
          cur_next     = cur_inc;
        end else if (!wr_pend) begin
          count_next      = count - CW'(1);
          res_status_next = ST_OK;
          state_next      = S_RESP;
        end else begin
          wr_pend_next = 1'b0;
        end
      end
      S_RESP: begin
        if (!out_valid || !out_stall) begin
          out_valid_next   = 1'b1;
          status_next      = res_status;
          entry_count_next = count_ext[COUNT_OUT_W-1:0];
          state_next       = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

@@ hw/rtl/skvt_checker.sv @@
module skvt_checker #(
  parameter int TABLE_DEPTH = skvt_pkg::DEFAULT_DEPTH
) (
  input logic                             clk,
  input logic                             rst,
  input logic                             in_valid,
  input logic                             in_stall,
  input logic                             out_valid,
  input logic                             out_stall,
  input logic [skvt_pkg::STATUS_W-1:0]    status,
  input logic [skvt_pkg::COUNT_OUT_W-1:0] entry_count
);

  import skvt_pkg::*;

  localparam bit COUNT_FITS = (TABLE_DEPTH < (1 << COUNT_OUT_W));

  // hold a stalled result word
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(status) && $stable(entry_count))
    else $error("stalled result word changed");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken again before the command finished");

  a_full_count: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == ST_FULL |-> !COUNT_FITS ||
      entry_count == COUNT_OUT_W'(TABLE_DEPTH))
    else $error("full status with a table that is not full");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !COUNT_FITS || entry_count <= COUNT_OUT_W'(TABLE_DEPTH))
    else $error("entry count above table depth");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != ST_OK && status != ST_FAIL |-> status == ST_FULL)
    else $error("undefined status code");

endmodule

bind sorted_key_value_table_top skvt_checker #(
  .TABLE_DEPTH(TABLE_DEPTH)
) u_skvt_checker (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (in_valid),
  .in_stall   (in_stall),
  .out_valid  (out_valid),
  .out_stall  (out_stall),
  .status     (status),
  .entry_count(entry_count)
);
